// ----- src/assert_macros.svh -----
// Shared assertion macros for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define RGBLED_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rgbled assertion failed");

`define RGBLED_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("rgbled forbidden condition seen");

`else

`define RGBLED_ASSERT(label, clk, rst_n, prop)

`define RGBLED_NEVER(label, clk, rst_n, expr)

`endif

`endif

// ----- src/rgbled_pkg.sv -----
package rgbled_pkg;

  localparam int PALETTE_SIZE = 8;

  localparam logic [7:0] CODE_ZERO    = 8'h60;
  localparam logic [7:0] CODE_ONE     = 8'h78;
  localparam logic [7:0] BRIGHT_RESET = 8'd32;
  localparam logic [4:0] LATCH_IDX    = 5'd24;

  typedef enum logic [1:0] {
    CMD_SET_WEIGHTS = 2'd0,
    CMD_PALETTE     = 2'd1,
    CMD_RAW         = 2'd2,
    CMD_REFRESH     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } chan_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_START,
    ST_WAIT,
    ST_SEND,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic        start;
    logic [15:0] dividend;
    logic [9:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic       busy;
    logic       done;
    logic [7:0] quotient;
  } div_rsp_t;

  function automatic rgb_t palette_weights(input logic [3:0] idx);
    rgb_t w;
    w = '0;
    if (int'(idx) < PALETTE_SIZE && idx < 4'd8) begin
      case (idx[2:0])
        3'd1:    w = '{red: 8'hFF, green: 8'h00, blue: 8'h00};
        3'd2:    w = '{red: 8'h00, green: 8'hFF, blue: 8'h00};
        3'd3:    w = '{red: 8'h00, green: 8'h00, blue: 8'hFF};
        3'd4:    w = '{red: 8'hFF, green: 8'hFF, blue: 8'h00};
        3'd5:    w = '{red: 8'h00, green: 8'hFF, blue: 8'hFF};
        3'd6:    w = '{red: 8'hFF, green: 8'h00, blue: 8'hFF};
        3'd7:    w = '{red: 8'hFF, green: 8'hFF, blue: 8'hFF};
        default: w = '0;
      endcase
    end
    return w;
  endfunction

endpackage

// ----- src/rgbled_div.sv -----
module rgbled_div (
  input  logic                clk,
  input  logic                rst_n,
  input  rgbled_pkg::div_req_t req,
  output rgbled_pkg::div_rsp_t rsp
);
  import rgbled_pkg::*;

  logic [9:0]  rem_r, rem_nxt;
  logic [15:0] quo_r, quo_nxt;
  logic [9:0]  dvs_r, dvs_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [10:0] trial;
  logic        fits;

  always_comb begin
    trial = {rem_r, quo_r[15]};
    fits  = trial >= {1'b0, dvs_r};
  end

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? 10'(trial - {1'b0, dvs_r}) : trial[9:0];
      quo_nxt = {quo_r[14:0], fits};
      cnt_nxt = cnt_r + 4'd1;
      if (cnt_r == 4'd15) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp = '{busy: busy_r, done: done_r, quotient: quo_r[7:0]};

endmodule

// ----- src/rgbled_enc.sv -----
`include "assert_macros.svh"

module rgbled_enc (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  rgbled_pkg::rgb_t  levels,
  output logic              busy,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,
  output logic              out_tuser,
  output logic              out_tlast
);
  import rgbled_pkg::*;

  logic       active_r, active_nxt;
  logic [4:0] idx_r, idx_nxt;
  rgb_t       lvl_r, lvl_nxt;
  logic [7:0] chan_level;
  logic [7:0] line_byte;
  logic       is_latch;

  always_comb begin
    case (idx_r[4:3])
      2'd0:    chan_level = lvl_r.green;
      2'd1:    chan_level = lvl_r.red;
      default: chan_level = lvl_r.blue;
    endcase
    is_latch  = idx_r == LATCH_IDX;
    line_byte = is_latch ? 8'h00 :
                (chan_level[3'd7 - idx_r[2:0]] ? CODE_ONE : CODE_ZERO);
  end

  always_comb begin
    active_nxt = active_r;
    idx_nxt    = idx_r;
    lvl_nxt    = lvl_r;
    if (start) begin
      active_nxt = 1'b1;
      idx_nxt    = '0;
      lvl_nxt    = levels;
    end else if (active_r && out_tready) begin
      if (is_latch) begin
        active_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      idx_r    <= '0;
    end else begin
      active_r <= active_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lvl_r <= lvl_nxt;
  end

  assign busy       = active_r;
  assign out_tvalid = active_r;
  assign out_tdata  = {lvl_r.blue, lvl_r.green, lvl_r.red, line_byte};
  assign out_tuser  = is_latch;
  assign out_tlast  = is_latch;

  `RGBLED_ASSERT(a_idx_in_range, clk, rst_n, active_r |-> idx_r <= LATCH_IDX)
  `RGBLED_NEVER(a_start_while_active, clk, rst_n, start && active_r)

endmodule

// ----- src/rgb_led_scaler_and_pulse_encoder_unit.sv -----
// Scales an RGB weight request by the brightness register (a raw-level request is sent
// unscaled) and sends it as one frame of 25 output words: 24 line-code bytes (0x60 for a
// zero bit, 0x78 for a one bit) in G-R-B order, MSB first, then a latch word with tuser
// and tlast high. A weighted request goes through one shared 16-step restoring divider,
// which computes brightness*weight/sum for each channel in turn (all levels are zero when
// the weight sum is zero). The input is held until the frame, including any output stall,
// has been sent; in_tready is high only while idle.
`include "assert_macros.svh"

module rgb_led_scaler_and_pulse_encoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,   // brightness
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // red, green, blue, color_index, zero pad
  input  logic [1:0]  in_tuser,    // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // line_byte, level_red, level_green, level_blue
  output logic        out_tuser,   // latch
  output logic        out_tlast
);
  import rgbled_pkg::*;

  state_t     state_r, state_nxt;
  logic [7:0] bright_r, bright_nxt;
  rgb_t       wgt_r, wgt_nxt;
  rgb_t       lvl_r, lvl_nxt;
  logic [9:0] sum_r, sum_nxt;
  chan_t      ch_r, ch_nxt;
  cmd_t       cmd;
  rgb_t       in_rgb;
  logic [7:0] wsel;
  div_req_t   div_req;
  div_rsp_t   div_rsp;
  logic       enc_start;
  logic       enc_busy;

  assign cmd    = cmd_t'(in_tuser);
  assign in_rgb = '{red: in_tdata[7:0], green: in_tdata[15:8], blue: in_tdata[23:16]};

  always_comb begin
    unique case (ch_r)
      CH_RED:   wsel = wgt_r.red;
      CH_GREEN: wsel = wgt_r.green;
      default:  wsel = wgt_r.blue;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = (cmd == CMD_RAW) ? ST_SEND : ST_SUM;
      ST_SUM:   state_nxt = ST_START;
      ST_START: state_nxt = (sum_r == '0) ? ST_SEND : ST_WAIT;
      ST_WAIT:  if (div_rsp.done) state_nxt = (ch_r == CH_BLUE) ? ST_SEND : ST_START;
      ST_SEND:  state_nxt = ST_DRAIN;
      ST_DRAIN: if (!enc_busy) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    bright_nxt       = cfg_we ? cfg_wdata : bright_r;
    wgt_nxt          = wgt_r;
    lvl_nxt          = lvl_r;
    sum_nxt          = sum_r;
    ch_nxt           = ch_r;
    div_req.start    = 1'b0;
    div_req.dividend = 16'(bright_r) * 16'(wsel);
    div_req.divisor  = sum_r;
    in_tready        = 1'b0;
    enc_start        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          unique case (cmd)
            CMD_SET_WEIGHTS: wgt_nxt = in_rgb;
            CMD_PALETTE:     wgt_nxt = palette_weights(in_tdata[27:24]);
            CMD_RAW:         lvl_nxt = in_rgb;
            default:         wgt_nxt = wgt_r;
          endcase
        end
      end
      ST_SUM: begin
        sum_nxt = 10'(wgt_r.red) + 10'(wgt_r.green) + 10'(wgt_r.blue);
        ch_nxt  = CH_RED;
      end
      ST_START: begin
        if (sum_r == '0) begin
          lvl_nxt = '0;
        end else begin
          div_req.start = 1'b1;
        end
      end
      ST_WAIT: begin
        if (div_rsp.done) begin
          unique case (ch_r)
            CH_RED:   lvl_nxt.red   = div_rsp.quotient;
            CH_GREEN: lvl_nxt.green = div_rsp.quotient;
            default:  lvl_nxt.blue  = div_rsp.quotient;
          endcase
          ch_nxt = chan_t'(ch_r + 2'd1);
        end
      end
      ST_SEND:  enc_start = 1'b1;
      default:  enc_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      bright_r <= BRIGHT_RESET;
      wgt_r    <= '0;
      ch_r     <= CH_RED;
    end else begin
      state_r  <= state_nxt;
      bright_r <= bright_nxt;
      wgt_r    <= wgt_nxt;
      ch_r     <= ch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lvl_r <= lvl_nxt;
    sum_r <= sum_nxt;
  end

  rgbled_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  rgbled_enc u_enc (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (enc_start),
    .levels     (lvl_r),
    .busy       (enc_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  `RGBLED_NEVER(a_ready_while_sending, clk, rst_n, in_tready && (enc_busy || div_rsp.busy))
  `RGBLED_ASSERT(a_done_only_in_wait, clk, rst_n, div_rsp.done |-> state_r == ST_WAIT)
  `RGBLED_ASSERT(a_send_starts_frame, clk, rst_n, state_r == ST_SEND |=> enc_busy)

endmodule
